@@ rtl/core/divider_and_reloading_timer_macros.svh @@
// Assertion macros shared by the timer RTL
`ifndef DIVIDER_AND_RELOADING_TIMER_MACROS_SVH
`define DIVIDER_AND_RELOADING_TIMER_MACROS_SVH
`ifndef ASSERT_OFF
`define DART_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define DART_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`define DART_ASSERT_RESET_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");
`else
`define DART_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DART_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define DART_ASSERT_RESET_NEXT(label, clk, ante, cons)
`endif
`endif

@@ rtl/core/dart_pkg.sv @@
// Types and constants of the divider and reloading timer
package dart_pkg;

    localparam int unsigned CYCLE_WRAP = 4194304;
    localparam int unsigned CYCLE_W    = $clog2(CYCLE_WRAP);
    localparam logic [CYCLE_W-1:0] CYCLE_LAST = CYCLE_W'(CYCLE_WRAP - 1);

    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_CNT = 16'hFF05;
    localparam logic [15:0] ADDR_REL = 16'hFF06;
    localparam logic [15:0] ADDR_CTL = 16'hFF07;

    localparam logic [7:0] CTL_ENABLE = 8'h04;
    localparam logic [7:0] CTL_SELECT = 8'h03;

    // log2 of the step periods 1024, 16, 64, 256 and of the divider period
    localparam int unsigned PER_1024_W = 10;
    localparam int unsigned PER_16_W   = 4;
    localparam int unsigned PER_64_W   = 6;
    localparam int unsigned PER_256_W  = 8;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        RATE_1024 = 2'd0,
        RATE_16   = 2'd1,
        RATE_64   = 2'd2,
        RATE_256  = 2'd3
    } rate_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       overflow;
    } result_t;

endpackage

@@ rtl/core/dart_core.sv @@
// Timer state and per-word register file logic
module dart_core
    import dart_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [CYCLE_W-1:0] cycle_count_reg, cycle_count_next;
    logic [7:0]         divider_reg, divider_next;
    logic [7:0]         timer_reg, timer_next;
    logic [7:0]         reload_reg, reload_next;
    logic [7:0]         control_reg, control_next;

    logic [CYCLE_W-1:0] cycle_inc;
    logic               rate_hit;
    logic               timer_on;
    rate_t              rate;

    assign cycle_inc = (cycle_count_reg == CYCLE_LAST) ? '0 : cycle_count_reg + 1'b1;
    assign timer_on  = (control_reg & CTL_ENABLE) != 8'h00;
    assign rate      = rate_t'(2'(control_reg & CTL_SELECT));

    always_comb begin
        case (rate)
            RATE_1024: rate_hit = cycle_inc[PER_1024_W-1:0] == '0;
            RATE_16:   rate_hit = cycle_inc[PER_16_W-1:0] == '0;
            RATE_64:   rate_hit = cycle_inc[PER_64_W-1:0] == '0;
            RATE_256:  rate_hit = cycle_inc[PER_256_W-1:0] == '0;
            default:   rate_hit = 1'b0;
        endcase
    end

    always_comb begin
        cycle_count_next = cycle_count_reg;
        divider_next     = divider_reg;
        timer_next       = timer_reg;
        reload_next      = reload_reg;
        control_next     = control_reg;
        result           = '0;
        case (item.op)
            OP_TICK: begin
                cycle_count_next = cycle_inc;
                if (cycle_inc[PER_256_W-1:0] == '0) begin
                    divider_next = divider_reg + 8'd1;
                end
                if (timer_on && rate_hit) begin
                    if (timer_reg == 8'hFF) begin
                        timer_next      = reload_reg;
                        result.overflow = 1'b1;
                    end else begin
                        timer_next = timer_reg + 8'd1;
                    end
                end
            end
            OP_READ: begin
                case (item.address)
                    ADDR_DIV: result.read_data = divider_reg;
                    ADDR_CNT: result.read_data = timer_reg;
                    ADDR_REL: result.read_data = reload_reg;
                    ADDR_CTL: result.read_data = control_reg;
                    default:  result.read_data = 8'h00;
                endcase
            end
            OP_WRITE: begin
                case (item.address)
                    ADDR_DIV: divider_next = 8'h00;
                    ADDR_CNT: timer_next   = item.write_data;
                    ADDR_REL: reload_next  = item.write_data;
                    ADDR_CTL: control_next = item.write_data;
                    default:  ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_count_reg <= '0;
            divider_reg     <= '0;
            timer_reg       <= '0;
            reload_reg      <= '0;
            control_reg     <= '0;
        end else if (step) begin
            cycle_count_reg <= cycle_count_next;
            divider_reg     <= divider_next;
            timer_reg       <= timer_next;
            reload_reg      <= reload_next;
            control_reg     <= control_next;
        end
    end

endmodule

@@ rtl/core/dart_out.sv @@
// Result register on the master side
module dart_out
    import dart_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              result,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] read_data, [8] overflow
);

    logic    valid_reg;
    result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 9){1'b0}}, data_reg.overflow, data_reg.read_data};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

@@ rtl/core/divider_and_reloading_timer.sv @@
// Top level of the divider and reloading timer
// One word is taken per clock while m_tready stays high: a tick (tuser 0), a bus read
// (1) or a bus write (2), and each word returns exactly one result word. A word
// passes an input register and is then applied to the timer registers in the same
// cycle that it lands in the result register. m_tdata[7:0] carries the read byte
// (zero for ticks, writes and unknown addresses), m_tdata[8] flags a tick on which
// the counter overflowed and reloaded. Registers: 0xFF04 divider (any write clears
// it), 0xFF05 counter, 0xFF06 reload value, 0xFF07 control (bit 2 enable, bits 1:0
// select 1024/16/64/256).
`include "divider_and_reloading_timer_macros.svh"
module divider_and_reloading_timer
    import dart_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]           s_tuser,   // [1:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] read_data, [8] overflow
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_free;
    logic    advance;
    result_t result;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op         <= op_t'(s_tuser);
            in_item_reg.address    <= s_tdata[15:0];
            in_item_reg.write_data <= s_tdata[23:16];
        end
    end

    dart_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    dart_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `DART_ASSERT_IMPLY(a_ovf_no_data, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'h00)
    `DART_ASSERT_NEXT(a_held_word_kept, aclk, aresetn, in_valid_reg && !out_free, in_valid_reg)
    `DART_ASSERT_RESET_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid && !in_valid_reg)

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the divider and reloading timer stream block
`timescale 1ns / 100ps
module tb
    import dart_pkg::*;
();

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         TAIL_CYCLES = 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [15:0] address, [23:16] write_data
    logic [1:0]           s_tuser  = '0;   // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [7:0] read_data, [8] overflow

    divider_and_reloading_timer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [CYCLE_W-1:0] cyc_q  = '0;
    logic [7:0]         div_q  = '0;
    logic [7:0]         cnt_q  = '0;
    logic [7:0]         rel_q  = '0;
    logic [7:0]         ctl_q  = '0;
    logic               last_ovf = 1'b0;

    result_t pending_results[$];
    result_t want_res;
    int      err_count     = 0;
    int      cycles        = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL divider_and_reloading_timer");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic result_t predict_timer(logic [1:0] op, logic [15:0] addr,
                                              logic [7:0] data);
        result_t     r;
        int unsigned period;
        r = '0;
        period = 256;
        case (op)
            OP_TICK: begin
                cyc_q = (cyc_q == CYCLE_LAST) ? '0 : cyc_q + 1'b1;
                if (cyc_q % 256 == 0)
                    div_q = div_q + 8'd1;
                if ((ctl_q & CTL_ENABLE) != 8'd0) begin
                    case (rate_t'(2'(ctl_q & CTL_SELECT)))
                        RATE_1024: period = 1024;
                        RATE_16:   period = 16;
                        RATE_64:   period = 64;
                        default:   period = 256;
                    endcase
                    if (cyc_q % period == 0) begin
                        cnt_q = cnt_q + 8'd1;
                        if (cnt_q == 8'd0) begin
                            r.overflow = 1'b1;
                            cnt_q = rel_q;
                        end
                    end
                end
            end
            OP_READ: begin
                case (addr)
                    ADDR_DIV: r.read_data = div_q;
                    ADDR_CNT: r.read_data = cnt_q;
                    ADDR_REL: r.read_data = rel_q;
                    ADDR_CTL: r.read_data = ctl_q;
                    default:  r.read_data = 8'd0;
                endcase
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_DIV: div_q = 8'd0;
                    ADDR_CNT: cnt_q = data;
                    ADDR_REL: rel_q = data;
                    ADDR_CTL: ctl_q = data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        last_ovf = r.overflow;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got 0x%0h want 0x%0h at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", int'(m_tdata), 0);
            end else begin
                want_res = pending_results.pop_front();
                if (m_tdata[7:0] !== want_res.read_data)
                    report_mismatch("read_data", int'(m_tdata[7:0]),
                                    int'(want_res.read_data));
                if (m_tdata[8] !== want_res.overflow)
                    report_mismatch("overflow", int'(m_tdata[8]),
                                    int'(want_res.overflow));
            end
        end
    end

    task automatic send_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(predict_timer(op, addr, data));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 16'($urandom), 8'($urandom));
    endtask

    task automatic test_reset_reads();
        send_word(OP_READ, ADDR_DIV, 8'h00);
        send_word(OP_READ, ADDR_CNT, 8'hFF);
        send_word(OP_READ, ADDR_REL, 8'h00);
        send_word(OP_READ, ADDR_CTL, 8'hFF);
        send_word(OP_READ, 16'h0000, 8'h00);
        send_word(OP_READ, 16'hFFFF, 8'hFF);
        send_word(OP_NONE, ADDR_CNT, 8'hFF);
        drain_results();
    endtask

    task automatic test_register_access();
        send_word(OP_WRITE, ADDR_REL, 8'hFF);
        send_word(OP_WRITE, ADDR_CTL, 8'hF8);
        send_word(OP_READ,  ADDR_CTL, 8'h00);
        send_word(OP_WRITE, ADDR_CNT, 8'h00);
        send_word(OP_READ,  ADDR_CNT, 8'h00);
        send_word(OP_WRITE, ADDR_DIV, 8'hAB);
        send_word(OP_READ,  ADDR_DIV, 8'h00);
        send_word(OP_WRITE, 16'hFF08, 8'h55);
        send_word(OP_NONE,  ADDR_REL, 8'h00);
        send_word(OP_READ,  ADDR_REL, 8'h00);
        drain_results();
    endtask

    task automatic test_fast_overflow();
        send_word(OP_WRITE, ADDR_REL, 8'hA5);
        send_word(OP_WRITE, ADDR_CTL, CTL_ENABLE | 8'(RATE_16));
        send_word(OP_WRITE, ADDR_CNT, 8'hFF);
        do
            send_tick();
        while (!last_ovf);
        send_word(OP_READ, ADDR_CNT, 8'h00);
        drain_results();
    endtask

    task automatic test_slow_overflow();
        send_word(OP_WRITE, ADDR_CTL, CTL_ENABLE | 8'(RATE_1024));
        send_word(OP_WRITE, ADDR_CNT, 8'hFF);
        do
            send_tick();
        while (!last_ovf);
        send_word(OP_READ, ADDR_DIV, 8'h00);
        send_word(OP_READ, ADDR_CNT, 8'h00);
        drain_results();
    endtask

    task automatic random_word(output logic [1:0] op, output logic [15:0] addr,
                               output logic [7:0] data);
        int pick;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (pick < 70) begin
            op = OP_TICK;
        end else if (pick < 82) begin
            op   = OP_READ;
            addr = ADDR_DIV + 16'($urandom_range(0, 3));
        end else if (pick < 90) begin
            op   = OP_WRITE;
            addr = ADDR_DIV + 16'($urandom_range(0, 3));
            if (addr == ADDR_CNT && $urandom_range(0, 3) != 0)
                data = 8'($urandom_range(8'hF0, 8'hFF));
            if (addr == ADDR_CTL && $urandom_range(0, 4) != 0)
                data = data | CTL_ENABLE;
        end else begin
            op = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 1) != 0)
                addr = 16'hFF00 + 16'($urandom_range(0, 15));
        end
    endtask

    task automatic test_random_traffic(int idle, int stall, int count);
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < count; i++) begin
            random_word(op, addr, data);
            send_word(op, addr, data);
            if (i == count / 2)
                drain_results();
        end
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_reads();
        test_register_access();
        test_fast_overflow();
        test_random_traffic(0, 0, 210);
        test_random_traffic(71, 0, 210);
        test_random_traffic(0, 71, 210);
        test_random_traffic(26, 26, 210);
        test_slow_overflow();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("words left over", pending_results.size(), 0);
        if (err_count == 0)
            $display("PASS divider_and_reloading_timer");
        else
            $display("FAIL divider_and_reloading_timer");
        $finish;
    end

endmodule
